>>> rtl/pwts_pkg.sv
// ----------------------------------------------------------------------------
// pwts_pkg
// Shared types, constants and the sine table builder for the polyphonic
// wavetable synthesizer.
// ----------------------------------------------------------------------------
`default_nettype none

package pwts_pkg;

    // Default configuration of the top level.
    localparam int VOICES_DEF     = 8;
    localparam int TABLE_BITS_DEF = 10;
    localparam int PFB_DEF        = 16;

    // Reset value of the increment scale register.
    localparam logic [31:0] SCALE_RESET = 32'd5726623;

    // Depth of the command queue between front and back.
    localparam int Q_DEPTH = 2;

    // Field widths of one input word.
    localparam int FUNC_W  = 2;
    localparam int VOICE_W = 3;
    localparam int FREQ_W  = 19;
    localparam int AMP_W   = 17;
    localparam int SAMP_W  = 16;

    // Function codes carried on the input tuser.
    localparam logic [FUNC_W-1:0] FUNC_NOTE_ON  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_NOTE_OFF = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK     = 2'd2;

    // Saturation limits of the mixed sample.
    localparam int SAMPLE_MAX = 32767;
    localparam int SAMPLE_MIN = -32768;

    // Pi in Q30 and one in Q30 for the table builder.
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    // Command kinds handed from the front to the back.
    typedef enum logic [1:0] {
        K_ON,
        K_OFF,
        K_TICK
    } t_kind;

    // One classified command.
    typedef struct packed {
        t_kind               kind;
        logic [VOICE_W-1:0]  voice;
        logic [FREQ_W-1:0]   freq;
        logic [AMP_W-1:0]    amp;
    } t_cmd;

    // Sine in Q30 for an argument in Q30 within the first quadrant, by an
    // eleven-term Taylor series.
    function automatic logic [63:0] sin_q30(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        x2   = (x * x) >> 30;
        term = x;
        sum  = x;
        term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
        term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
        term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
        term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
        term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
        term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
        term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
        term = ((term * x2) >> 30) / 64'd272; sum = sum + term;
        term = ((term * x2) >> 30) / 64'd342; sum = sum - term;
        term = ((term * x2) >> 30) / 64'd420; sum = sum + term;
        if (sum > ONE_Q30) begin
            sum = ONE_Q30;
        end
        return sum;
    endfunction

    // One table entry: 32767 times the sine, truncated, for a table of
    // two to the tbits entries. Built from the first quadrant by symmetry.
    function automatic logic signed [15:0] sine_entry(input int unsigned i,
                                                      input int unsigned tbits);
        int unsigned half;
        int unsigned quarter;
        int unsigned j;
        logic [63:0] x;
        logic [63:0] s;
        logic [15:0] v;
        half    = (32'd1 << tbits) >> 1;
        quarter = (32'd1 << tbits) >> 2;
        j       = (i < half) ? i : i - half;
        if (j > quarter) begin
            j = half - j;
        end
        if (j == quarter) begin
            v = 16'd32767;
        end else begin
            x = (PI_Q30 * 64'(j)) >> (tbits - 1);
            s = sin_q30(x);
            v = 16'((s * 64'd32767) >> 30);
        end
        return (i < half) ? $signed(v) : -$signed(v);
    endfunction

endpackage

`default_nettype wire

>>> rtl/pwts_front.sv
// ----------------------------------------------------------------------------
// pwts_front
// Accepts input words, decodes the function code and drops words that
// address no voice or carry an unused code. Valid commands go to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module pwts_front
    import pwts_pkg::*;
#(
    parameter int VOICES = VOICES_DEF
) (
    input  wire logic                      s_axis_tvalid,
    output logic                           s_axis_tready,
    // Fields from bit 0: voice[2:0], freq_hz[21:3], amplitude[38:22], zero.
    input  wire logic [39:0]               s_axis_tdata,
    // Fields from bit 0: func[1:0].
    input  wire logic [FUNC_W-1:0]         s_axis_tuser,
    input  wire logic                      i_q_full,
    output logic                           o_push,
    output t_cmd                           o_cmd
);

    logic voice_ok;
    logic keep;

    // The word is taken whenever the queue has room; dropped words never push.
    assign s_axis_tready = !i_q_full;

    assign voice_ok = (32'(s_axis_tdata[2:0]) < 32'(VOICES));

    // Classify the word.
    always_comb begin
        o_cmd.voice = s_axis_tdata[2:0];
        o_cmd.freq  = s_axis_tdata[21:3];
        o_cmd.amp   = s_axis_tdata[38:22];
        o_cmd.kind  = K_TICK;
        keep        = 1'b0;
        case (s_axis_tuser)
            FUNC_NOTE_ON: begin
                o_cmd.kind = K_ON;
                keep       = voice_ok;
            end
            FUNC_NOTE_OFF: begin
                o_cmd.kind = K_OFF;
                keep       = voice_ok;
            end
            FUNC_TICK: begin
                o_cmd.kind = K_TICK;
                keep       = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_push = s_axis_tvalid && s_axis_tready && keep;

endmodule

`default_nettype wire

>>> rtl/pwts_queue.sv
// ----------------------------------------------------------------------------
// pwts_queue
// Small command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module pwts_queue
    import pwts_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    output logic      o_valid,
    output t_cmd      o_head,
    input  wire logic i_pop
);

    localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCW = $clog2(Q_DEPTH + 1);

    t_cmd           r_mem [Q_DEPTH];
    logic [QAW-1:0] r_wptr;
    logic [QAW-1:0] r_rptr;
    logic [QCW-1:0] r_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == QCW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == QAW'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == QAW'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/pwts_back.sv
// ----------------------------------------------------------------------------
// pwts_back
// Carries out commands: note on computes and stores a voice's increment,
// note off clears its active bit, a tick sweeps the voices one per cycle
// through a four-stage pipeline and emits the saturated mix.
// ----------------------------------------------------------------------------
`default_nettype none

module pwts_back
    import pwts_pkg::*;
#(
    parameter int VOICES     = VOICES_DEF,
    parameter int TABLE_BITS = TABLE_BITS_DEF,
    parameter int PFB        = PFB_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wen,
    input  wire logic [31:0]       i_cfg_wdata,
    input  wire logic              i_q_valid,
    input  wire t_cmd              i_q_head,
    output logic                   o_q_pop,
    output logic                   o_tvalid,
    input  wire logic              i_tready,
    output logic [2*SAMP_W-1:0]    o_tdata
);

    localparam int VW        = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int PB        = TABLE_BITS + PFB;
    localparam int TABLE_LEN = 1 << TABLE_BITS;
    localparam int SH        = 32 - PFB;
    localparam int PROD_W    = FREQ_W + 16;
    localparam int FULL_W    = FREQ_W + 32;
    localparam int MUL_W     = SAMP_W + AMP_W + 1;
    localparam int CON_W     = MUL_W - 16;
    localparam int ACC_W     = CON_W + VW;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(SAMPLE_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(SAMPLE_MIN);

    typedef logic signed [SAMP_W-1:0] t_rom [TABLE_LEN];

    typedef struct packed {
        logic [PB-1:0]    phase;
        logic [PB-1:0]    inc;
        logic [AMP_W-1:0] gain;
    } t_voice;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_SUM   = 6'b000100,
        S_SWEEP = 6'b001000,
        S_DRAIN = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    function automatic t_rom build_rom();
        t_rom rom;
        for (int i = 0; i < TABLE_LEN; i++) begin
            rom[i] = sine_entry(i, TABLE_BITS);
        end
        return rom;
    endfunction

    localparam t_rom SINE = build_rom();

    t_state              r_state;
    t_state              n_state;
    logic [31:0]         r_scale;
    logic [VOICES-1:0]   r_active;
    logic [VW-1:0]       r_cnt;
    logic [VW-1:0]       r_vidx;
    logic [FREQ_W-1:0]   r_freq;
    logic [AMP_W-1:0]    r_amp;
    logic [PROD_W-1:0]   r_pp_lo;
    logic [PROD_W-1:0]   r_pp_hi;

    // Voice parameter memory, one write and one read port.
    t_voice              r_vmem [VOICES];
    t_voice              r_rd_data;
    logic                wr_en;
    logic [VW-1:0]       wr_addr;
    t_voice              wr_data;

    // Sweep pipeline.
    logic                r_a_valid;
    logic                r_a_act;
    logic [VW-1:0]       r_a_idx;
    logic                r_b_valid;
    logic [AMP_W-1:0]    r_b_gain;
    logic signed [SAMP_W-1:0] r_rom_q;
    logic                r_c_valid;
    logic signed [MUL_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]  r_acc;

    logic                r_out_valid;
    logic [SAMP_W-1:0]   r_out_data;

    logic [FULL_W-1:0]   full_prod;
    logic [FULL_W-1:0]   shifted;
    logic [PB-1:0]       new_inc;
    logic signed [MUL_W-1:0]  rounded;
    logic signed [CON_W-1:0]  contrib;
    logic [SAMP_W-1:0]   sat;
    logic                out_free;
    logic                drained;
    logic [VW-1:0]       head_idx;

    assign head_idx = VW'(i_q_head.voice);
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign out_free = !r_out_valid || i_tready;
    assign drained  = !r_a_valid && !r_b_valid && !r_c_valid;

    // Increment: product of frequency and scale, shifted and clamped.
    assign full_prod = {16'b0, r_pp_lo} + {r_pp_hi, 16'b0};
    assign shifted   = full_prod >> SH;
    assign new_inc   = (|shifted[FULL_W-1:PB]) ? {PB{1'b1}} : shifted[PB-1:0];

    // Divide the product by 2^16, truncating toward zero.
    assign rounded = r_prod + (r_prod[MUL_W-1] ? MUL_W'(65535) : '0);
    assign contrib = rounded[MUL_W-1:16];

    // Saturate the mix to 16 bits.
    always_comb begin
        if (r_acc > SAT_HI) begin
            sat = SAMP_W'(SAMPLE_MAX);
        end else if (r_acc < SAT_LO) begin
            sat = SAMP_W'(SAMPLE_MIN);
        end else begin
            sat = r_acc[SAMP_W-1:0];
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_head.kind)
                        K_ON:    n_state = S_MUL;
                        K_TICK:  n_state = S_SWEEP;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_MUL:   n_state = S_SUM;
            S_SUM:   n_state = S_IDLE;
            S_SWEEP: begin
                if (r_cnt == VW'(VOICES - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (drained) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Memory write port: note on stores a fresh voice, the sweep writes the
    // advanced phase back.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_a_idx;
        wr_data = r_rd_data;
        if (r_state == S_SUM) begin
            wr_en         = 1'b1;
            wr_addr       = r_vidx;
            wr_data.phase = '0;
            wr_data.inc   = new_inc;
            wr_data.gain  = r_amp;
        end else if (r_a_valid && r_a_act) begin
            wr_en         = 1'b1;
            wr_data.phase = r_rd_data.phase + r_rd_data.inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_vmem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_vmem[r_cnt];
    end

    // Sine table read at the voice's integer phase.
    always_ff @(posedge i_clk) begin
        r_rom_q <= SINE[r_rd_data.phase[PB-1:PFB]];
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_vidx <= head_idx;
            r_freq <= i_q_head.freq;
            r_amp  <= i_q_head.amp;
        end
        r_pp_lo  <= r_freq * r_scale[15:0];
        r_pp_hi  <= r_freq * r_scale[31:16];
        r_a_idx  <= r_cnt;
        r_b_gain <= r_rd_data.gain;
        r_prod   <= r_rom_q * $signed({1'b0, r_b_gain});
        if (r_state == S_EMIT && out_free) begin
            r_out_data <= sat;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_scale     <= SCALE_RESET;
            r_active    <= '0;
            r_cnt       <= '0;
            r_a_valid   <= 1'b0;
            r_a_act     <= 1'b0;
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wen) begin
                r_scale <= i_cfg_wdata;
            end

            // Active bits and sweep start.
            if (o_q_pop) begin
                case (i_q_head.kind)
                    K_OFF: r_active[head_idx] <= 1'b0;
                    K_TICK: begin
                        r_cnt <= '0;
                        r_acc <= '0;
                    end
                    default: ;
                endcase
            end
            if (r_state == S_SUM) begin
                r_active[r_vidx] <= 1'b1;
            end

            // Sweep counter and pipeline valids.
            if (r_state == S_SWEEP && r_cnt != VW'(VOICES - 1)) begin
                r_cnt <= r_cnt + 1'b1;
            end
            r_a_valid <= (r_state == S_SWEEP);
            r_a_act   <= r_active[r_cnt];
            r_b_valid <= r_a_valid && r_a_act;
            r_c_valid <= r_b_valid;
            if (r_c_valid) begin
                r_acc <= r_acc + ACC_W'(contrib);
            end

            // Output register.
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_tvalid = r_out_valid;
    assign o_tdata  = {r_out_data, r_out_data};

endmodule

`default_nettype wire

>>> rtl/polyphonic_wavetable_synth.sv
// ----------------------------------------------------------------------------
// polyphonic_wavetable_synth
// Polyphonic sine synthesizer: note on/off and sample ticks in, one mixed
// stereo sample out per tick.
//
//   Channel   Direction  Content
//   s_axis    in         tuser func; tdata voice, freq_hz, amplitude
//   m_axis    out        tdata left_sample, right_sample
//   cfg       in         increment_scale, written on i_cfg_wen
//
// A tick holds the back for the pop, one voice per cycle through the voice
// memory read port, the drain of the three pipeline stages behind it, and
// the emit state, which waits until the output register is free.
// A note on passes the pop, partial products and sum states; a note off ends at the pop.
// Reset is synchronous and needs no clearing pass. The front keeps taking
// words while the queue has room; the back holds a finished sample in its
// output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module polyphonic_wavetable_synth
    import pwts_pkg::*;
#(
    parameter int VOICES     = VOICES_DEF,
    parameter int TABLE_BITS = TABLE_BITS_DEF,
    parameter int PFB        = PFB_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wen,
    input  wire logic [31:0]            i_cfg_wdata,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // Fields from bit 0: voice[2:0], freq_hz[21:3], amplitude[38:22], zero.
    input  wire logic [39:0]            s_axis_tdata,
    // Fields from bit 0: func[1:0].
    input  wire logic [FUNC_W-1:0]      s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // Fields from bit 0: left_sample[15:0], right_sample[31:16].
    output logic [2*SAMP_W-1:0]         m_axis_tdata
);

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_cmd push_cmd;
    t_cmd head_cmd;

    pwts_front #(
        .VOICES (VOICES)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_cmd         (push_cmd)
    );

    pwts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head_cmd),
        .i_pop   (q_pop)
    );

    pwts_back #(
        .VOICES     (VOICES),
        .TABLE_BITS (TABLE_BITS),
        .PFB        (PFB)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_q_head    (head_cmd),
        .o_q_pop     (q_pop),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tdata     (m_axis_tdata)
    );

endmodule

`default_nettype wire

>>> rtl/pwts_checker.sv
// ----------------------------------------------------------------------------
// pwts_checker
// Port-level checks on the synthesizer's output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module pwts_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);

    // A stalled output word holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // Both channels carry the same mixed sample.
    a_same_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:0] == m_axis_tdata[31:16])
        else $error("left and right samples differ");

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind polyphonic_wavetable_synth pwts_checker u_pwts_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// Polyphonic wavetable synthesizer testbench
// Drives note-on, note-off, tick and unused-code words into the stream
// input under random idling on both sides, and rewrites the increment scale
// between phases. A behavioral copy of the synthesizer, with its own sine
// table, predicts every mixed sample. Each output word is checked field by
// field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pwts_pkg::*;

    localparam int          VOICE_COUNT = 8;
    localparam int          TAB_BITS    = 10;
    localparam int          TAB_LEN     = 1 << TAB_BITS;
    localparam int          FRAC_BITS   = 16;
    localparam int          PHASE_W     = TAB_BITS + FRAC_BITS;
    localparam logic [63:0] PHASE_FULL  = (64'd1 << PHASE_W) - 64'd1;
    localparam logic [63:0] PI_Q30_TB   = 64'd3373259426;
    localparam logic [63:0] UNIT_Q30    = 64'd1 << 30;
    localparam logic [31:0] SCALE_AT_RESET = 32'd5726623;
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;

    // Long enough for a tick or a note on in the back; two more may sit queued.
    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT   = 5000;
    localparam int IDLE_PERCENT  = 32;

    typedef struct packed {
        logic signed [SAMP_W-1:0] right;
        logic signed [SAMP_W-1:0] left;
    } t_stereo;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wen = 1'b0;
    logic [31:0]           i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [39:0]           s_axis_tdata = '0;
    logic [FUNC_W-1:0]     s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [2*SAMP_W-1:0]   m_axis_tdata;

    // Predicted synthesizer state.
    logic signed [15:0]    sine_table [TAB_LEN];
    logic [PHASE_W-1:0]    voice_phase [VOICE_COUNT];
    logic [PHASE_W-1:0]    voice_step [VOICE_COUNT];
    logic [AMP_W-1:0]      voice_gain [VOICE_COUNT];
    bit                    voice_on [VOICE_COUNT];
    logic [31:0]           increment_scale;

    t_stereo               expected_mix [$];
    t_stereo               seen_mix;
    t_stereo               want_mix;
    int                    errors = 0;
    int                    quiet_cycles = 0;
    bit                    steady_flow = 1'b0;

    polyphonic_wavetable_synth dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Sine of a first-quadrant angle in Q30 by an eleven-term Taylor series,
    // with unsigned wraparound exactly as the fixed-point original.
    function automatic logic [63:0] taylor_sine_q30(input logic [63:0] ang);
        logic [63:0] sq;
        logic [63:0] term;
        logic [63:0] acc;
        int          k;
        sq   = (ang * ang) >> 30;
        term = ang;
        acc  = ang;
        for (k = 1; k <= 10; k++) begin
            term = ((term * sq) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        if (acc > UNIT_Q30) begin
            acc = UNIT_Q30;
        end
        return acc;
    endfunction

    // Fill the sine table from the first quadrant and clear every voice.
    task automatic reset_synth_model();
        int          i;
        int          j;
        logic [15:0] mag;
        for (i = 0; i < TAB_LEN; i++) begin
            j = (i < TAB_LEN / 2) ? i : i - TAB_LEN / 2;
            if (j > TAB_LEN / 4) begin
                j = TAB_LEN / 2 - j;
            end
            if (j == TAB_LEN / 4) begin
                mag = 16'd32767;
            end else begin
                mag = 16'((taylor_sine_q30((PI_Q30_TB * 64'(j)) >> (TAB_BITS - 1))
                           * 64'd32767) >> 30);
            end
            sine_table[i] = (i < TAB_LEN / 2) ? $signed(mag) : -$signed(mag);
        end
        for (i = 0; i < VOICE_COUNT; i++) begin
            voice_phase[i] = '0;
            voice_step[i]  = '0;
            voice_gain[i]  = '0;
            voice_on[i]    = 1'b0;
        end
        increment_scale = SCALE_AT_RESET;
    endtask

    // Apply one accepted word to the predicted state; a tick queues a sample.
    task automatic apply_synth_word(input logic [FUNC_W-1:0] func,
                                    input logic [VOICE_W-1:0] voice,
                                    input logic [FREQ_W-1:0] freq,
                                    input logic [AMP_W-1:0] amp);
        logic [63:0] wide;
        longint      prod;
        longint      mix;
        t_stereo     sample;
        int          k;
        case (func)
            FUNC_NOTE_ON: begin
                wide = (64'(freq) * 64'(increment_scale)) >> (32 - FRAC_BITS);
                if (wide > PHASE_FULL) begin
                    wide = PHASE_FULL;
                end
                voice_phase[voice] = '0;
                voice_step[voice]  = wide[PHASE_W-1:0];
                voice_gain[voice]  = amp;
                voice_on[voice]    = 1'b1;
            end
            FUNC_NOTE_OFF: begin
                voice_on[voice] = 1'b0;
            end
            FUNC_TICK: begin
                mix = 0;
                for (k = 0; k < VOICE_COUNT; k++) begin
                    if (voice_on[k]) begin
                        prod = longint'(sine_table[voice_phase[k][PHASE_W-1:FRAC_BITS]])
                               * longint'(voice_gain[k]);
                        // Scale toward zero, not toward minus infinity.
                        if (prod < 0) begin
                            mix = mix - ((-prod) >>> 16);
                        end else begin
                            mix = mix + (prod >>> 16);
                        end
                        voice_phase[k] = voice_phase[k] + voice_step[k];
                    end
                end
                if (mix > 32767) begin
                    mix = 32767;
                end else if (mix < -32768) begin
                    mix = -32768;
                end
                sample.left  = 16'(mix);
                sample.right = 16'(mix);
                expected_mix.push_back(sample);
            end
            default: begin
            end
        endcase
    endtask

    // Receiver side: randomly stall unless the flow is held steady.
    always @(posedge i_clk) begin
        m_axis_tready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Check every output word, feed the predictor with every input word
    // and watch for a stalled handshake.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            quiet_cycles++;
            if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
                quiet_cycles = 0;
                seen_mix = m_axis_tdata;
                if (expected_mix.size() == 0) begin
                    errors++;
                    $display("%0t: sample word with none expected, actual %0d/%0d",
                             $time, seen_mix.left, seen_mix.right);
                end else begin
                    want_mix = expected_mix.pop_front();
                    if (seen_mix.left !== want_mix.left) begin
                        errors++;
                        $display("%0t: left sample expected %0d, actual %0d",
                                 $time, want_mix.left, seen_mix.left);
                    end
                    if (seen_mix.right !== want_mix.right) begin
                        errors++;
                        $display("%0t: right sample expected %0d, actual %0d",
                                 $time, want_mix.right, seen_mix.right);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready === 1'b1) begin
                quiet_cycles = 0;
                apply_synth_word(s_axis_tuser, s_axis_tdata[2:0], s_axis_tdata[21:3],
                                 s_axis_tdata[38:22]);
            end
            if (i_cfg_wen) begin
                increment_scale = i_cfg_wdata;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Send one word; tvalid is left high so back-to-back words need no
    // drop, and the caller lowers it before any wait.
    task automatic push_word(input logic [FUNC_W-1:0] func,
                             input logic [VOICE_W-1:0] voice,
                             input logic [FREQ_W-1:0] freq,
                             input logic [AMP_W-1:0] amp);
        while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {1'b0, amp, freq, voice};
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
    endtask

    // Hold the sender until every sample has arrived and notes have settled.
    task automatic drain_synth();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_mix.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_scale(input logic [31:0] value);
        drain_synth();
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_wen   <= 1'b0;
    endtask

    // Silence, the unused code, zero and maximum fields, and note off on
    // both a sounding and an already silent voice, at the reset scale.
    task automatic test_basic_notes();
        push_word(FUNC_TICK, 3'd0, '0, '0);
        push_word(FUNC_SPARE, 3'd5, 19'h7FFFF, 17'h1FFFF);
        push_word(FUNC_NOTE_ON, 3'd0, 19'd7040, 17'd65536);
        push_word(FUNC_NOTE_ON, 3'd1, 19'd0, 17'd0);
        push_word(FUNC_NOTE_ON, 3'd2, 19'd393215, 17'h1FFFF);
        push_word(FUNC_NOTE_ON, 3'd7, 19'd1, 17'd1);
        push_word(FUNC_TICK, 3'd0, '0, '0);
        push_word(FUNC_TICK, 3'd0, '0, '0);
        push_word(FUNC_NOTE_OFF, 3'd2, '0, '0);
        push_word(FUNC_NOTE_OFF, 3'd5, '0, '0);
        push_word(FUNC_TICK, 3'd0, '0, '0);
    endtask

    // All voices at gain above full scale, a quarter table per tick:
    // the mix clips high at the crest and low at the trough.
    task automatic test_saturation();
        int v;
        write_scale(32'd1 << 22);
        for (v = 0; v < VOICE_COUNT; v++) begin
            push_word(FUNC_NOTE_ON, 3'(v), 19'd262144, 17'h1FFFF);
        end
        repeat (4) push_word(FUNC_TICK, 3'd0, '0, '0);
    endtask

    // Largest scale and a large frequency: the increment clamps below one table.
    task automatic test_increment_clamp();
        write_scale(32'hFFFF_FFFF);
        push_word(FUNC_NOTE_ON, 3'd3, 19'd393215, 17'd65536);
        push_word(FUNC_TICK, 3'd0, '0, '0);
        push_word(FUNC_TICK, 3'd0, '0, '0);
    endtask

    // Mostly notes and ticks with musical content, some full-range noise.
    task automatic test_random_mix(input int words, input logic [31:0] scale,
                                   input bit steady);
        int                 n;
        int                 pick;
        logic [FUNC_W-1:0]  func;
        logic [FREQ_W-1:0]  freq;
        logic [AMP_W-1:0]   amp;
        write_scale(scale);
        steady_flow = steady;
        for (n = 0; n < words; n++) begin
            pick = $urandom_range(99);
            if (pick < 40) begin
                func = FUNC_TICK;
            end else if (pick < 70) begin
                func = FUNC_NOTE_ON;
            end else if (pick < 94) begin
                func = FUNC_NOTE_OFF;
            end else begin
                func = FUNC_SPARE;
            end
            pick = $urandom_range(9);
            if (pick < 4) begin
                freq = 19'($urandom_range(16 * 5000, 16 * 20));
            end else if (pick < 8) begin
                freq = 19'($urandom_range(19'h7FFFF));
            end else begin
                freq = 19'($urandom_range(64));
            end
            pick = $urandom_range(3);
            if (pick == 0) begin
                amp = 17'd65536;
            end else if (pick == 1) begin
                amp = 17'($urandom_range(17'h1FFFF));
            end else begin
                amp = 17'($urandom_range(65536));
            end
            push_word(func, 3'($urandom_range(7)), freq, amp);
        end
        s_axis_tvalid <= 1'b0;
        steady_flow = 1'b0;
    endtask

    initial begin
        reset_synth_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_notes();
        test_saturation();
        test_increment_clamp();
        test_random_mix(100, SCALE_AT_RESET, 1'b0);
        test_random_mix(100, 32'd0, 1'b0);
        test_random_mix(100, 32'hFFFF_FFFF, 1'b0);
        test_random_mix(100, $urandom, 1'b1);
        test_random_mix(100, 32'($urandom_range(32'd1 << 22, 1)), 1'b0);

        drain_synth();
        if (expected_mix.size() != 0) begin
            errors++;
            $display("%0t: %0d expected samples never arrived", $time, expected_mix.size());
        end
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/pwts_pkg.sv
rtl/pwts_front.sv
rtl/pwts_queue.sv
rtl/pwts_back.sv
rtl/polyphonic_wavetable_synth.sv
rtl/pwts_checker.sv
sim/testbench.sv
